@@ src/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants of the three stage audio timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS    = 3;
  localparam int FAST_TIMER    = 2;
  localparam int FREQ_SLOW_DEF = 192;
  localparam int FREQ_FAST_DEF = 24;

  localparam int ACC_W  = 8;
  localparam int STEP_W = 5;
  localparam int DIV_W  = 8;
  localparam int CNT_W  = 4;
  localparam int MASK_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE_STEP = 3'd0,
    CFG_GLOBAL_ENABLE = 3'd1,
    CFG_GLOBAL_DISABLE = 3'd2,
    CFG_TIMER_ENABLE  = 3'd3,
    CFG_TARGET0       = 3'd4,
    CFG_TARGET1       = 3'd5,
    CFG_TARGET2       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              adv;
    logic              gate_open;
    logic              div_en;
    logic [STEP_W-1:0] step;
    logic [DIV_W-1:0]  target;
  } tmr_ctrl_t;

endpackage

@@ src/stb_if.sv @@
// ----------------------------------------------------------------------------
// stb_if
// valid/ready channels of the timer bank: tick input and count result
// ----------------------------------------------------------------------------
interface stb_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface stb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] count_timer0;
  logic [3:0] count_timer1;
  logic [3:0] count_timer2;

  modport source (output valid, output count_timer0, output count_timer1,
                  output count_timer2, input ready);
  modport sink (input valid, input count_timer0, input count_timer1,
                input count_timer2, output ready);
endinterface

@@ src/stb_timer.sv @@
// ----------------------------------------------------------------------------
// stb_timer
// one timer: prescale accumulator, gated stage line, divider, output counter
// ----------------------------------------------------------------------------
module stb_timer
  import stb_pkg::*;
#(
  parameter int FREQ = FREQ_SLOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_ctrl_t        ctrl,
  output logic [CNT_W-1:0] cnt_nxt
);

  localparam logic [ACC_W:0] FREQ_W = (ACC_W+1)'(FREQ);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             toggle_r, toggle_nxt;
  logic             gated_r, gated_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic [ACC_W:0]   sum;
  logic [ACC_W:0]   diff;
  logic [DIV_W-1:0] div_inc;
  logic             line;

  always_comb begin
    sum        = {1'b0, acc_r} + (ACC_W+1)'(ctrl.step);
    diff       = sum - FREQ_W;
    div_inc    = div_r + DIV_W'(1);
    acc_nxt    = acc_r;
    toggle_nxt = toggle_r;
    gated_nxt  = gated_r;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    line       = 1'b0;
    if (ctrl.adv) begin
      if (sum < FREQ_W) begin
        acc_nxt = sum[ACC_W-1:0];
      end else begin
        acc_nxt    = diff[ACC_W-1:0];
        toggle_nxt = ~toggle_r;
        line       = toggle_nxt & ctrl.gate_open;
        gated_nxt  = line;
        if (gated_r && !line && ctrl.div_en) begin
          if (div_inc == ctrl.target) begin
            div_nxt = '0;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            div_nxt = div_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      toggle_r <= 1'b0;
      gated_r  <= 1'b0;
      div_r    <= '0;
      cnt_r    <= '0;
    end else begin
      acc_r    <= acc_nxt;
      toggle_r <= toggle_nxt;
      gated_r  <= gated_nxt;
      div_r    <= div_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // state holds without an advancing transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.adv |=> $stable(acc_r) && $stable(toggle_r) && $stable(div_r) && $stable(cnt_r))
    else $error("timer state changed without advance");

  // counter only steps by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_nxt != cnt_r) |-> (cnt_nxt == cnt_r + CNT_W'(1)) && (div_nxt == '0))
    else $error("output counter stepped wrongly");

  // gated line is low after an overflow step taken while the gate is closed
  a_gate: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.adv && !ctrl.gate_open && (sum >= FREQ_W) |=> !gated_r)
    else $error("gated line high with gate closed");

endmodule

@@ src/three_stage_audio_timer_bank.sv @@
// ----------------------------------------------------------------------------
// three_stage_audio_timer_bank
// three prescaled timers with gated stage lines, dividers and 4-bit counters
// ----------------------------------------------------------------------------
// in_if carries one tick per transaction; tick = 1 advances all three timers
// by one step, tick = 0 only reports the counts. every input transaction
// yields exactly one out_if transaction with the three 4-bit counts after it.
// an accepted transaction passes the input register, then one pass of the
// timer logic into the result register, which drives out_if.valid; a stall
// on out_if can hold it in the input register. one transaction per cycle,
// set by the single pass, while out_if.ready does not hold the flow.
// when out_if.ready is low a full result register holds, the input register
// still accepts one more transaction, and in_if.ready drops once both are
// full. cfg_we writes register cfg_idx with cfg_data at a clock edge; index 7
// is ignored. write configuration only while the bank is idle.
// reset (rst_n low, synchronous) clears all timer state, both pipeline valid
// bits, and loads the register defaults: step 1, global enable set,
// global disable clear, timer enables clear, all targets 0 (meaning 256).
// ----------------------------------------------------------------------------
module three_stage_audio_timer_bank
  import stb_pkg::*;
#(
  parameter int FREQ_SLOW = FREQ_SLOW_DEF,
  parameter int FREQ_FAST = FREQ_FAST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  stb_in_if.sink                in_if,
  stb_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [STEP_W-1:0] step_r;
  logic              gen_r;
  logic              gdis_r;
  logic [MASK_W-1:0] ten_r;
  logic [DIV_W-1:0]  target_r [NUM_TIMERS];

  logic              in_v_r;
  logic              tick_r;
  logic              out_v_r;
  logic [CNT_W-1:0]  out_cnt_r [NUM_TIMERS];
  logic [CNT_W-1:0]  cnt_nxt [NUM_TIMERS];

  logic              advance;
  logic              process;

  assign advance     = !out_v_r || out_if.ready;
  assign process     = in_v_r && advance;
  assign in_if.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_W'(1);
      gen_r  <= 1'b1;
      gdis_r <= 1'b0;
      ten_r  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        target_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PRESCALE_STEP:  step_r      <= cfg_data[STEP_W-1:0];
        CFG_GLOBAL_ENABLE:  gen_r       <= cfg_data[0];
        CFG_GLOBAL_DISABLE: gdis_r      <= cfg_data[0];
        CFG_TIMER_ENABLE:   ten_r       <= cfg_data[MASK_W-1:0];
        CFG_TARGET0:        target_r[0] <= cfg_data[DIV_W-1:0];
        CFG_TARGET1:        target_r[1] <= cfg_data[DIV_W-1:0];
        CFG_TARGET2:        target_r[2] <= cfg_data[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      tick_r <= in_if.tick;
    end
    if (process) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        out_cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
    tmr_ctrl_t ctrl;

    assign ctrl.adv       = process && tick_r;
    assign ctrl.gate_open = gen_r && !gdis_r;
    assign ctrl.div_en    = ten_r[g];
    assign ctrl.step      = step_r;
    assign ctrl.target    = target_r[g];

    stb_timer #(
      .FREQ ((g == FAST_TIMER) ? FREQ_FAST : FREQ_SLOW)
    ) u_timer (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cnt_nxt (cnt_nxt[g])
    );
  end

  assign out_if.valid        = out_v_r;
  assign out_if.count_timer0 = out_cnt_r[0];
  assign out_if.count_timer1 = out_cnt_r[1];
  assign out_if.count_timer2 = out_cnt_r[2];

  // a processed transaction always lands in the result register
  a_process: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> out_v_r)
    else $error("processed transaction lost");

  // a stalled input stage keeps its transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(tick_r))
    else $error("input stage dropped a stalled transaction");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_if.ready |=> out_v_r && $stable(out_cnt_r[0])
      && $stable(out_cnt_r[1]) && $stable(out_cnt_r[2]))
    else $error("result changed while stalled");

endmodule

@@ test/three_stage_audio_timer_bank_tb.sv @@
// ----------------------------------------------------------------------------
// three_stage_audio_timer_bank_tb
// self-checking testbench of the three stage audio timer bank
// ----------------------------------------------------------------------------
// tick transactions are pushed into a pending queue and sent over the input
// channel under random sender idling. every accepted tick is run through a
// local model of the three timers, and the predicted counts are compared
// with each accepted result transaction while the receiver stalls at random.
// registers are rewritten between phases only, each time the bank is idle.
// ----------------------------------------------------------------------------
module three_stage_audio_timer_bank_tb;
  import stb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NUM_TIMERS-1:0][CNT_W-1:0] counts_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [ACC_W:0] FREQ_SLOW_9 = (ACC_W+1)'(FREQ_SLOW_DEF);
  localparam logic [ACC_W:0] FREQ_FAST_9 = (ACC_W+1)'(FREQ_FAST_DEF);
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  stb_in_if in_ch ();
  stb_out_if out_ch ();

  three_stage_audio_timer_bank uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // model configuration
  logic [STEP_W-1:0] step_cfg;
  logic gate_en;
  logic gate_dis;
  logic [MASK_W-1:0] en_mask;
  logic [DIV_W-1:0] target [NUM_TIMERS];

  // model timer state
  logic [ACC_W-1:0] acc [NUM_TIMERS];
  logic toggle [NUM_TIMERS];
  logic gated [NUM_TIMERS];
  logic [DIV_W-1:0] div [NUM_TIMERS];
  logic [CNT_W-1:0] cnt [NUM_TIMERS];

  logic tick_q [$];
  counts_t count_q [$];

  int send_idle;
  int recv_idle;
  int errors;
  int n_in;
  int n_out;
  int n_settings;
  int stall_cycles;

  always #4 clk = ~clk;

  function automatic counts_t step_timers(input logic tick);
    logic [ACC_W:0] sum;
    logic [ACC_W:0] freq;
    logic line;
    logic prev;
    counts_t res;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (tick) begin
        freq = (t == FAST_TIMER) ? FREQ_FAST_9 : FREQ_SLOW_9;
        sum = {1'b0, acc[t]} + (ACC_W+1)'(step_cfg);
        if (sum < freq) begin
          acc[t] = sum[ACC_W-1:0];
        end else begin
          sum = sum - freq;
          acc[t] = sum[ACC_W-1:0];
          toggle[t] = ~toggle[t];
          line = toggle[t] & gate_en & ~gate_dis;
          prev = gated[t];
          gated[t] = line;
          if (prev && !line && en_mask[t]) begin
            div[t] = div[t] + DIV_W'(1);
            if (div[t] == target[t]) begin
              div[t] = '0;
              cnt[t] = cnt[t] + CNT_W'(1);
            end
          end
        end
      end
      res[t] = cnt[t];
    end
    return res;
  endfunction

  // keeps the low bits, fills the rest with random junk
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int width);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'($urandom);
    for (int b = 0; b < width; b++) r[b] = value[b];
    return r;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_PRESCALE_STEP: step_cfg = data[STEP_W-1:0];
      CFG_GLOBAL_ENABLE: gate_en = data[0];
      CFG_GLOBAL_DISABLE: gate_dis = data[0];
      CFG_TIMER_ENABLE: en_mask = data[MASK_W-1:0];
      CFG_TARGET0: target[0] = data;
      CFG_TARGET1: target[1] = data;
      CFG_TARGET2: target[2] = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] en,
                                input logic [CFG_DATA_W-1:0] dis, input logic [CFG_DATA_W-1:0] mask,
                                input logic [CFG_DATA_W-1:0] t0, input logic [CFG_DATA_W-1:0] t1,
                                input logic [CFG_DATA_W-1:0] t2);
    cfg_write(CFG_PRESCALE_STEP, step);
    cfg_write(CFG_GLOBAL_ENABLE, en);
    cfg_write(CFG_GLOBAL_DISABLE, dis);
    cfg_write(CFG_TIMER_ENABLE, mask);
    cfg_write(CFG_TARGET0, t0);
    cfg_write(CFG_TARGET1, t1);
    cfg_write(CFG_TARGET2, t2);
    cfg_write(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || count_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) tick_q.push_back($urandom_range(0, 9) != 0);
    wait_idle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return with_junk(0, DIV_W);
      1: return with_junk(255, DIV_W);
      2: return CFG_DATA_W'($urandom_range(0, 255));
      default: return CFG_DATA_W'($urandom_range(1, 3));
    endcase
  endfunction

  // input driver, predicts on every accepted tick
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.tick <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        count_q.push_back(step_timers(in_ch.tick));
        n_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.tick <= tick_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    counts_t got;
    counts_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.count_timer2, out_ch.count_timer1, out_ch.count_timer0};
        n_out++;
        if (count_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected count transaction, expected none, got %h", $time, got);
        end else begin
          want = count_q.pop_front();
          for (int t = 0; t < NUM_TIMERS; t++) begin
            if (got[t] !== want[t]) begin
              errors++;
              $display("%0t: count_timer%0d expected %0d got %0d", $time, t, want[t], got[t]);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.tick = 1'b0;
    out_ch.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_settings = 0;
    stall_cycles = 0;
    step_cfg = 5'd1;
    gate_en = 1'b1;
    gate_dis = 1'b0;
    en_mask = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      target[t] = '0;
      acc[t] = '0;
      toggle[t] = 1'b0;
      gated[t] = 1'b0;
      div[t] = '0;
      cnt[t] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, idle and active ticks
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    wait_idle();

    // wide writes, largest step above the fast frequency
    apply_settings(8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'h01, 8'h02, 8'h01);
    for (int i = 0; i < 17; i++) tick_q.push_back(i != 8);
    wait_idle();

    // global disable holds every stage line low
    apply_settings(8'h1F, 8'h01, 8'h01, 8'h07, 8'h01, 8'h01, 8'h01);
    for (int i = 0; i < 4; i++) tick_q.push_back(1'b1);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      send_idle = (ph < 3) ? 19 : (ph < 6) ? 45 : 0;
      recv_idle = (ph < 3) ? 45 : (ph < 6) ? 19 : 0;
      apply_settings(
        with_junk((ph == 0) ? 0 : (ph == 1) ? 31 : $urandom_range(16, 31), STEP_W),
        with_junk(int'($urandom_range(0, 4) != 0), 1),
        with_junk(int'($urandom_range(0, 4) == 0), 1),
        with_junk(($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 7, MASK_W),
        pick_target(), pick_target(), pick_target());
      run_ticks(60);
    end

    // divider wrap through zero target on the fast timer, paused halfway
    apply_settings(8'h1F, 8'h01, 8'h00, 8'h07, 8'h03, 8'hFF, 8'h00);
    run_ticks(290);
    run_ticks(290);

    $display("sent %0d tick transactions under %0d register settings", n_in, n_settings);
    $display("checked %0d count transactions, %0d mismatches", n_out, errors);
    if (errors == 0 && count_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ three_stage_audio_timer_bank.f @@
src/stb_pkg.sv
src/stb_if.sv
src/stb_timer.sv
src/three_stage_audio_timer_bank.sv
test/three_stage_audio_timer_bank_tb.sv
